// ===== hdl/bblc_pkg.sv =====
// Package for the Bayer black level correction block.
// Shared constants, register map, channel codes and control structs.
// No dependencies.
package bblc_pkg;

    // Word and field widths
    localparam int PIXEL_BITS_DEF = 14;
    localparam int RAW_W          = 16;
    localparam int OFFSET_W       = 15;
    localparam int WP_W           = 14;
    localparam int WP_RESET       = 16383;

    // Normalization ratio fixed point
    localparam int RATIO_SHIFT    = 10;
    localparam int RATIO_ONE      = 1024;
    localparam int ROUND_HALF     = 512;

    // APB port
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_BYPASS  = 3'd0,
        REG_PATTERN = 3'd1,
        REG_OFF_R   = 3'd2,
        REG_OFF_GR  = 3'd3,
        REG_OFF_GB  = 3'd4,
        REG_OFF_B   = 3'd5,
        REG_NORM    = 3'd6,
        REG_WHITE   = 3'd7
    } reg_idx_t;

    // Color channel; channel = raster position XOR mosaic order
    typedef enum logic [1:0] {
        CH_R  = 2'd0,
        CH_GR = 2'd1,
        CH_GB = 2'd2,
        CH_B  = 2'd3
    } chan_t;

    // Configuration registers
    typedef struct packed {
        logic                       bypass_on;
        logic [1:0]                 mosaic_order;
        logic signed [OFFSET_W-1:0] offset_red;
        logic signed [OFFSET_W-1:0] offset_green_red;
        logic signed [OFFSET_W-1:0] offset_green_blue;
        logic signed [OFFSET_W-1:0] offset_blue;
        logic                       normalize_on;
        logic [WP_W-1:0]            white_point;
    } cfg_t;

    // Request to the ratio divider
    typedef struct packed {
        logic            load;
        logic [WP_W-1:0] divisor;
    } div_req_t;

endpackage

// ===== hdl/bblc_regs.sv =====
// APB register file of the black level correction block.
// Holds the configuration and issues a divider request on a white point write.
// Depends on bblc_pkg.
module bblc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bblc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bblc_pkg::DATA_W-1:0]  pwdata,
    output logic [bblc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output bblc_pkg::cfg_t               cfg,
    output bblc_pkg::div_req_t           div_req
);
    import bblc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_BYPASS:  cfg_next.bypass_on         = pwdata[0];
                REG_PATTERN: cfg_next.mosaic_order      = pwdata[1:0];
                REG_OFF_R:   cfg_next.offset_red        = pwdata[OFFSET_W-1:0];
                REG_OFF_GR:  cfg_next.offset_green_red  = pwdata[OFFSET_W-1:0];
                REG_OFF_GB:  cfg_next.offset_green_blue = pwdata[OFFSET_W-1:0];
                REG_OFF_B:   cfg_next.offset_blue       = pwdata[OFFSET_W-1:0];
                REG_NORM:    cfg_next.normalize_on      = pwdata[0];
                REG_WHITE:   cfg_next.white_point       = pwdata[WP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bypass_on         <= 1'b0;
            cfg_reg.mosaic_order      <= 2'd0;
            cfg_reg.offset_red        <= '0;
            cfg_reg.offset_green_red  <= '0;
            cfg_reg.offset_green_blue <= '0;
            cfg_reg.offset_blue       <= '0;
            cfg_reg.normalize_on      <= 1'b0;
            cfg_reg.white_point       <= WP_W'(WP_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // Divider start; a zero white point counts as one
    assign div_req.load    = wr && (idx == REG_WHITE);
    assign div_req.divisor = (pwdata[WP_W-1:0] == '0) ? WP_W'(1) : pwdata[WP_W-1:0];

    // Read back, offsets sign-extended
    always_comb
    begin
        unique case (idx)
            REG_BYPASS:  prdata = DATA_W'(cfg_reg.bypass_on);
            REG_PATTERN: prdata = DATA_W'(cfg_reg.mosaic_order);
            REG_OFF_R:   prdata = {{(DATA_W-OFFSET_W){cfg_reg.offset_red[OFFSET_W-1]}},
                                   cfg_reg.offset_red};
            REG_OFF_GR:  prdata = {{(DATA_W-OFFSET_W){cfg_reg.offset_green_red[OFFSET_W-1]}},
                                   cfg_reg.offset_green_red};
            REG_OFF_GB:  prdata = {{(DATA_W-OFFSET_W){cfg_reg.offset_green_blue[OFFSET_W-1]}},
                                   cfg_reg.offset_green_blue};
            REG_OFF_B:   prdata = {{(DATA_W-OFFSET_W){cfg_reg.offset_blue[OFFSET_W-1]}},
                                   cfg_reg.offset_blue};
            REG_NORM:    prdata = DATA_W'(cfg_reg.normalize_on);
            REG_WHITE:   prdata = DATA_W'(cfg_reg.white_point);
        endcase
    end

endmodule

// ===== hdl/bblc_div.sv =====
// Restoring divider for the normalization ratio, MAXV*1024 / white point.
// One quotient bit per cycle; busy while it runs.
// Depends on bblc_pkg.
module bblc_div #(
    parameter int PIXEL_BITS = bblc_pkg::PIXEL_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  bblc_pkg::div_req_t                             req,
    output logic                                           busy,
    output logic [PIXEL_BITS+bblc_pkg::RATIO_SHIFT-1:0]    ratio
);
    import bblc_pkg::*;

    localparam int NUM_W = PIXEL_BITS + RATIO_SHIFT;
    localparam int MAXV  = (1 << PIXEL_BITS) - 1;
    localparam int IDX_W = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] NUMER     = NUM_W'(MAXV * RATIO_ONE);
    localparam logic [NUM_W-1:0] RATIO_RST = NUM_W'((MAXV * RATIO_ONE) / WP_RESET);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [NUM_W-1:0] ratio_reg, ratio_next;
    logic [WP_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [WP_W-1:0]  dvs_reg, dvs_next;

    logic [WP_W:0]    trial;
    logic [WP_W:0]    diff;
    logic             ge;
    logic [NUM_W-1:0] quo_shift;

    // One restoring step: bring down the next numerator bit
    assign trial     = {rem_reg, NUMER[idx_reg]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign ge        = (trial >= {1'b0, dvs_reg});
    assign quo_shift = {quo_reg[NUM_W-2:0], ge};

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        ratio_next = ratio_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (req.load)
        begin
            busy_next = 1'b1;
            idx_next  = IDX_W'(NUM_W - 1);
            rem_next  = '0;
            quo_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[WP_W-1:0] : trial[WP_W-1:0];
            quo_next = quo_shift;
            if (idx_reg == '0)
            begin
                busy_next  = 1'b0;
                ratio_next = quo_shift;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    // Control and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            ratio_reg <= RATIO_RST;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            ratio_reg <= ratio_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy  = busy_reg;
    assign ratio = ratio_reg;

endmodule

// ===== hdl/bblc_pipe.sv =====
// Pixel pipeline: parity tracking and offset select, subtract and clamp,
// then normalization multiply and output register. Depends on bblc_pkg.
module bblc_pipe #(
    parameter int PIXEL_BITS = bblc_pkg::PIXEL_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          accept,
    input  logic [bblc_pkg::RAW_W-1:0]                    raw_pixel,
    input  logic                                          frame_start,
    input  logic                                          line_end,
    input  bblc_pkg::cfg_t                                cfg,
    input  logic [PIXEL_BITS+bblc_pkg::RATIO_SHIFT-1:0]   ratio,
    input  logic                                          out_stall,
    output logic                                          ready,
    output logic                                          out_valid,
    output logic [bblc_pkg::RAW_W-1:0]                    corrected_pixel
);
    import bblc_pkg::*;

    localparam int DROP   = RAW_W - PIXEL_BITS;
    localparam int MAXV   = (1 << PIXEL_BITS) - 1;
    localparam int DIFF_W = ((PIXEL_BITS > OFFSET_W) ? PIXEL_BITS : OFFSET_W) + 2;
    localparam int PROD_W = 2 * PIXEL_BITS + RATIO_SHIFT + 1;

    // Stage handshake
    logic ready1, ready2, ready3;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    assign ready3 = !out_valid_reg || !out_stall;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;
    assign ready  = ready1;

    assign s1_valid_next  = accept || (s1_valid_reg && !ready2);
    assign s2_valid_next  = ready2 ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = ready3 ? s2_valid_reg : out_valid_reg;

    // Row and column parity
    logic  row_reg, row_next, col_reg, col_next;
    logic  row_eff, col_eff;
    chan_t chan;
    logic signed [OFFSET_W-1:0] off_sel;

    assign row_eff = frame_start ? 1'b0 : row_reg;
    assign col_eff = frame_start ? 1'b0 : col_reg;
    assign chan    = chan_t'({row_eff, col_eff} ^ cfg.mosaic_order);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (line_end)
            begin
                col_next = 1'b0;
                row_next = !row_eff;
            end
            else
            begin
                col_next = !col_eff;
                row_next = row_eff;
            end
        end
    end

    // Black level of the pixel's channel
    always_comb
    begin
        unique case (chan)
            CH_R:  off_sel = cfg.offset_red;
            CH_GR: off_sel = cfg.offset_green_red;
            CH_GB: off_sel = cfg.offset_green_blue;
            CH_B:  off_sel = cfg.offset_blue;
        endcase
    end

    // Stage 1: cut pixel and chosen offset
    logic [PIXEL_BITS-1:0]      s1_pix_reg, s1_pix_next;
    logic signed [OFFSET_W-1:0] s1_off_reg, s1_off_next;

    assign s1_pix_next = accept ? raw_pixel[RAW_W-1:DROP] : s1_pix_reg;
    assign s1_off_next = accept ? off_sel : s1_off_reg;

    // Stage 2: subtract and clamp, or bypass
    logic signed [DIFF_W-1:0] pix_ext, off_ext, diff;
    logic [PIXEL_BITS-1:0]    clamped;
    logic [PIXEL_BITS-1:0]    s2_val_reg, s2_val_next;

    assign pix_ext = signed'(DIFF_W'(s1_pix_reg));
    assign off_ext = DIFF_W'(s1_off_reg);
    assign diff    = pix_ext - off_ext;

    always_comb
    begin
        priority if (diff < 0)
            clamped = '0;
        else if (diff > signed'(DIFF_W'(MAXV)))
            clamped = PIXEL_BITS'(MAXV);
        else
            clamped = diff[PIXEL_BITS-1:0];
    end

    assign s2_val_next = (ready2 && s1_valid_reg)
                       ? (cfg.bypass_on ? s1_pix_reg : clamped)
                       : s2_val_reg;

    // Stage 3: normalization multiply, round, shift, clamp, or pass through
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     scaled;
    logic [PIXEL_BITS-1:0] normed;
    logic [PIXEL_BITS-1:0] res;
    logic [RAW_W-1:0]      out_pix_reg, out_pix_next;

    assign prod   = PROD_W'(s2_val_reg) * PROD_W'(ratio) + PROD_W'(ROUND_HALF);
    assign scaled = prod >> RATIO_SHIFT;
    assign normed = (scaled > PROD_W'(MAXV)) ? PIXEL_BITS'(MAXV) : scaled[PIXEL_BITS-1:0];
    assign res    = (cfg.normalize_on && !cfg.bypass_on) ? normed : s2_val_reg;

    assign out_pix_next = (ready3 && s2_valid_reg) ? (RAW_W'(res) << DROP) : out_pix_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= 1'b0;
            col_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_pix_reg  <= s1_pix_next;
        s1_off_reg  <= s1_off_next;
        s2_val_reg  <= s2_val_next;
        out_pix_reg <= out_pix_next;
    end

    assign out_valid       = out_valid_reg;
    assign corrected_pixel = out_pix_reg;

endmodule

// ===== hdl/bayer_black_level_correct.sv =====
// Bayer black level correction top: register file, ratio divider, pixel pipeline; uses bblc_pkg.
// One word per cycle sustained while out_stall and the ratio divider leave the input free,
// through a three-register pipeline: stage 1, stage 2 and the output register.
// A white point write runs the bit-serial ratio divider; input is stalled from the
// write's access cycle until the divider is done.
// rst_n is asynchronous: clears pipeline, parities and registers; ratio resets to 1024.
module bayer_black_level_correct #(
    parameter int PIXEL_BITS = bblc_pkg::PIXEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input stream
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bblc_pkg::RAW_W-1:0]   raw_pixel,
    input  logic                         frame_start,
    input  logic                         line_end,
    // Output stream
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bblc_pkg::RAW_W-1:0]   corrected_pixel,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bblc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bblc_pkg::DATA_W-1:0]  pwdata,
    output logic [bblc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import bblc_pkg::*;

    cfg_t                              cfg;
    div_req_t                          div_req;
    logic                              div_busy;
    logic [PIXEL_BITS+RATIO_SHIFT-1:0] ratio;
    logic                              pipe_ready;
    logic                              accept;

    // Hold input while the pipeline is full or the ratio is being recomputed
    assign in_stall = !pipe_ready || div_busy || div_req.load;
    assign accept   = in_valid && !in_stall;

    bblc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .div_req (div_req)
    );

    bblc_div #(.PIXEL_BITS(PIXEL_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .ratio (ratio)
    );

    bblc_pipe #(.PIXEL_BITS(PIXEL_BITS)) u_pipe (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .raw_pixel       (raw_pixel),
        .frame_start     (frame_start),
        .line_end        (line_end),
        .cfg             (cfg),
        .ratio           (ratio),
        .out_stall       (out_stall),
        .ready           (pipe_ready),
        .out_valid       (out_valid),
        .corrected_pixel (corrected_pixel)
    );

endmodule

// ===== hdl/bblc_checker.sv =====
// Port-level checker for the black level correction block, bound to the top.
// Depends on bblc_pkg.
module bblc_checker #(
    parameter int PIXEL_BITS = bblc_pkg::PIXEL_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [bblc_pkg::RAW_W-1:0]   corrected_pixel,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [bblc_pkg::ADDR_W-1:0]  paddr
);
    import bblc_pkg::*;

    localparam logic [RAW_W-1:0] LOW_MASK = RAW_W'((1 << (RAW_W - PIXEL_BITS)) - 1);

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(corrected_pixel))
        else $error("result word changed while stalled");

    // Bits below the pixel field are zero on a valid result word
    a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((corrected_pixel & LOW_MASK) == '0))
        else $error("low bits of corrected pixel not zero");

    // A white point write is followed by in_stall as the ratio recomputation starts
    a_wp_stall: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_WHITE) |=> in_stall)
        else $error("input taken during ratio update");

endmodule

bind bayer_black_level_correct bblc_checker #(.PIXEL_BITS(PIXEL_BITS)) u_bblc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .corrected_pixel (corrected_pixel),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr)
);
